// ===== design/mrf_pkg.sv =====
// Shared types and constants for the multiplicative range fold block.
// Used by multiplicative_range_fold and mrf_div; no dependencies.
`default_nettype none
package mrf_pkg;

  localparam int DataW        = 32;
  localparam int CfgIdxW      = 2;
  localparam int MaxStepsDef  = 1024;
  localparam int FracBitsDef  = 16;

  typedef struct packed {
    logic start;
    logic step;
  } div_ctrl_t;

endpackage
`default_nettype wire

// ===== design/mrf_div.sv =====
// Bit-serial restoring divider: quotient of a fixed-point shifted value by the step factor.
// One quotient bit per step beat from the sequencer; depends on mrf_pkg.
`default_nettype none
module mrf_div #(
  parameter int FRAC_BITS = mrf_pkg::FracBitsDef
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire mrf_pkg::div_ctrl_t     ctrl_i,
  input  wire [mrf_pkg::DataW-1:0]    value_i,
  input  wire [mrf_pkg::DataW-1:0]    divisor_i,
  output logic [mrf_pkg::DataW-1:0]   quotient_o,
  output logic                        last_o
);
  import mrf_pkg::*;

  localparam int DivW = DataW + FRAC_BITS;
  localparam int CntW = $clog2(DivW);

  logic [DivW-1:0]  dq_q, dq_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW:0]   rem_sh;
  logic [DataW:0]   rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, dq_q[DivW-1]};
  assign rem_sub = rem_sh - {1'b0, divisor_i};
  assign ge      = rem_sh >= {1'b0, divisor_i};

  always_comb begin
    dq_d  = dq_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (ctrl_i.start) begin
      dq_d  = {value_i, {FRAC_BITS{1'b0}}};
      rem_d = '0;
      cnt_d = '0;
    end else if (ctrl_i.step) begin
      dq_d  = {dq_q[DivW-2:0], ge};
      rem_d = ge ? rem_sub[DataW-1:0] : rem_sh[DataW-1:0];
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
  end

  assign quotient_o = dq_q[DataW-1:0];
  assign last_o     = cnt_q == CntW'(DivW - 1);

endmodule
`default_nettype wire

// ===== design/multiplicative_range_fold.sv =====
// Top level of the multiplicative range fold: stream ports, settings, microcoded sequencer.
// Depends on mrf_pkg and mrf_div.
//
// One sample is folded at a time. A rejected sample (zero or negative) goes straight to output.
// Otherwise each divide step runs through the bit-serial divider, and each multiply step
// goes through the registered multiplier; each sample also passes setup, tests and output.
// At most MAX_STEPS steps are done per sample, after which cap_reached is raised. The input
// accepts a new sample as soon as the sequencer is back at its idle step, even while the
// previous result waits in the output register.
`default_nettype none
module multiplicative_range_fold #(
  parameter int MAX_STEPS = mrf_pkg::MaxStepsDef,
  parameter int FRAC_BITS = mrf_pkg::FracBitsDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire [mrf_pkg::DataW-1:0]     s_axis_tdata,   // [31:0] sample_in
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [mrf_pkg::DataW-1:0]    m_axis_tdata,   // [31:0] folded
  output logic [1:0]                   m_axis_tuser,   // [0] rejected, [1] cap_reached
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [mrf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire [mrf_pkg::DataW-1:0]     cfg_data_i
);
  import mrf_pkg::*;

  localparam int StepW = $clog2(MAX_STEPS + 1);
  localparam int ProdW = 2 * DataW;
  localparam int PW    = ProdW - FRAC_BITS;

  localparam longint FixOneL    = longint'(1) << FRAC_BITS;
  localparam logic [DataW-1:0] FixOne    = DataW'(FixOneL);
  localparam logic [DataW-1:0] FixTenth  = DataW'((FixOneL + 5) / 10);
  localparam logic [DataW-1:0] FixOneTen = DataW'((FixOneL * 11 + 5) / 10);
  localparam logic [StepW-1:0] StepCap   = StepW'(MAX_STEPS);

  localparam logic [CfgIdxW-1:0] RegLower = 2'd0;
  localparam logic [CfgIdxW-1:0] RegUpper = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFactor = 2'd2;

  typedef enum logic [2:0] {
    OP_NOP, OP_LOAD, OP_DIV_START, OP_DIV_STEP, OP_TAKE_Q, OP_MUL, OP_TAKE_P, OP_SET_CAP
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_NO_INPUT, C_REJ, C_LE_HI, C_CAP, C_DIV_BUSY, C_GE_LO, C_NO_GROW,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e        op;
    logic       emit;
    cond_e      cond;
    logic [3:0] target;
  } uword_t;

  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StChkRej  = 4'd1;
  localparam logic [3:0] StDnTest  = 4'd2;
  localparam logic [3:0] StDnCap   = 4'd3;
  localparam logic [3:0] StDivInit = 4'd4;
  localparam logic [3:0] StDivIter = 4'd5;
  localparam logic [3:0] StDivDone = 4'd6;
  localparam logic [3:0] StUpTest  = 4'd7;
  localparam logic [3:0] StMul     = 4'd8;
  localparam logic [3:0] StMulChk  = 4'd9;
  localparam logic [3:0] StUpCap   = 4'd10;
  localparam logic [3:0] StTakeP   = 4'd11;
  localparam logic [3:0] StSetCap  = 4'd12;
  localparam logic [3:0] StEmit    = 4'd13;
  localparam logic [3:0] StReturn  = 4'd14;

  function automatic uword_t rom_word(input logic [3:0] pc);
    uword_t w;
    w = '{op: OP_NOP, emit: 1'b0, cond: C_ALWAYS, target: StIdle};
    case (pc)
      StIdle:    w = '{op: OP_LOAD,      emit: 1'b0, cond: C_NO_INPUT, target: StIdle};
      StChkRej:  w = '{op: OP_NOP,       emit: 1'b0, cond: C_REJ,      target: StEmit};
      StDnTest:  w = '{op: OP_NOP,       emit: 1'b0, cond: C_LE_HI,    target: StUpTest};
      StDnCap:   w = '{op: OP_NOP,       emit: 1'b0, cond: C_CAP,      target: StSetCap};
      StDivInit: w = '{op: OP_DIV_START, emit: 1'b0, cond: C_NEVER,    target: StIdle};
      StDivIter: w = '{op: OP_DIV_STEP,  emit: 1'b0, cond: C_DIV_BUSY, target: StDivIter};
      StDivDone: w = '{op: OP_TAKE_Q,    emit: 1'b0, cond: C_ALWAYS,   target: StDnTest};
      StUpTest:  w = '{op: OP_NOP,       emit: 1'b0, cond: C_GE_LO,    target: StEmit};
      StMul:     w = '{op: OP_MUL,       emit: 1'b0, cond: C_NEVER,    target: StIdle};
      StMulChk:  w = '{op: OP_NOP,       emit: 1'b0, cond: C_NO_GROW,  target: StEmit};
      StUpCap:   w = '{op: OP_NOP,       emit: 1'b0, cond: C_CAP,      target: StSetCap};
      StTakeP:   w = '{op: OP_TAKE_P,    emit: 1'b0, cond: C_ALWAYS,   target: StUpTest};
      StSetCap:  w = '{op: OP_SET_CAP,   emit: 1'b0, cond: C_ALWAYS,   target: StEmit};
      StEmit:    w = '{op: OP_NOP,       emit: 1'b1, cond: C_OUT_BUSY, target: StEmit};
      StReturn:  w = '{op: OP_NOP,       emit: 1'b0, cond: C_ALWAYS,   target: StIdle};
      default:   w = '{op: OP_NOP,       emit: 1'b0, cond: C_ALWAYS,   target: StIdle};
    endcase
    return w;
  endfunction

  logic [DataW-1:0] lower_q, upper_q, factor_q;
  logic [DataW-1:0] lo_eff, hi_eff, fac_eff;
  logic [DataW-1:0] lo_q, hi_q, fac_q, v_q;
  logic [ProdW-1:0] prod_q;
  logic [StepW-1:0] steps_q;
  logic             rej_q, cap_q;
  logic [3:0]       pc_q, pc_d;
  logic             m_valid_q;
  logic [DataW-1:0] m_data_q;
  logic [1:0]       m_user_q;

  uword_t           uw;
  logic             jump;
  logic             in_fire, out_busy, raw_rej;
  logic [PW-1:0]    p_w;
  logic [DataW-1:0] quotient;
  logic             div_last;
  div_ctrl_t        div_ctrl;

  assign uw       = rom_word(pc_q);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_busy = m_valid_q && !m_axis_tready;
  assign raw_rej  = (s_axis_tdata == '0) || s_axis_tdata[DataW-1];
  assign p_w      = prod_q[ProdW-1:FRAC_BITS];

  assign lo_eff  = (lower_q == '0) ? FixTenth : lower_q;
  assign hi_eff  = (upper_q < lo_eff) ? lo_eff : upper_q;
  assign fac_eff = (factor_q <= FixOne) ? FixOneTen : factor_q;

  assign div_ctrl.start = uw.op == OP_DIV_START;
  assign div_ctrl.step  = uw.op == OP_DIV_STEP;

  mrf_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .value_i    (v_q),
    .divisor_i  (fac_q),
    .quotient_o (quotient),
    .last_o     (div_last)
  );

  always_comb begin
    unique case (uw.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_INPUT: jump = !s_axis_tvalid;
      C_REJ:      jump = rej_q;
      C_LE_HI:    jump = v_q <= hi_q;
      C_CAP:      jump = steps_q >= StepCap;
      C_DIV_BUSY: jump = !div_last;
      C_GE_LO:    jump = v_q >= lo_q;
      C_NO_GROW:  jump = (p_w > PW'(hi_q)) || (p_w <= PW'(v_q));
      C_OUT_BUSY: jump = out_busy;
      default:    jump = 1'b1;
    endcase
    pc_d = jump ? uw.target : pc_q + 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= StIdle;
      m_valid_q <= 1'b0;
      lower_q   <= FixTenth;
      upper_q   <= FixTenth;
      factor_q  <= FixOneTen;
      steps_q   <= '0;
      rej_q     <= 1'b0;
      cap_q     <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegLower:  lower_q  <= cfg_data_i;
          RegUpper:  upper_q  <= cfg_data_i;
          RegFactor: factor_q <= cfg_data_i;
          default:   ;
        endcase
      end
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (uw.emit && !out_busy) begin
        m_valid_q <= 1'b1;
      end
      unique case (uw.op)
        OP_LOAD: begin
          if (in_fire) begin
            steps_q <= '0;
            rej_q   <= raw_rej;
            cap_q   <= 1'b0;
          end
        end
        OP_TAKE_Q, OP_TAKE_P: steps_q <= steps_q + 1'b1;
        OP_SET_CAP:           cap_q   <= 1'b1;
        default:              ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (uw.op)
      OP_LOAD: begin
        if (in_fire) begin
          v_q   <= raw_rej ? '0 : s_axis_tdata;
          lo_q  <= lo_eff;
          hi_q  <= hi_eff;
          fac_q <= fac_eff;
        end
      end
      OP_TAKE_Q: v_q    <= quotient;
      OP_MUL:    prod_q <= v_q * fac_q;
      OP_TAKE_P: v_q    <= p_w[DataW-1:0];
      default:   ;
    endcase
    if (uw.emit && !out_busy) begin
      m_data_q <= v_q;
      m_user_q <= {cap_q, rej_q};
    end
  end

  assign s_axis_tready = pc_q == StIdle;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule
`default_nettype wire
